/* hdl/jnp_pkg.sv */
// ----------------------------------------------------------------------------
// jnp_pkg
// Shared types, character codes and status codes for the number parser.
// ----------------------------------------------------------------------------
package jnp_pkg;

	localparam logic [31:0] MAX_POS    = 32'h7FFF_FFFF;
	localparam logic [31:0] NEAR_LIMIT = 32'd2147483640;
	localparam logic [31:0] MIN_MAG    = 32'h8000_0000;
	localparam logic [31:0] TEN        = 32'd10;
	// (x * RECIP10) >> 35 equals x / 10 for every 32-bit x
	localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LO_E  = 8'h65;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_FRAC     = 3'd1;
	localparam logic [2:0] STS_SYNTAX   = 3'd2;
	localparam logic [2:0] STS_OVERFLOW = 3'd3;
	localparam logic [2:0] STS_EOF      = 3'd4;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty_req;
	} char_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} result_t;

	typedef enum logic [3:0] {
		PH_START = 4'd0,
		PH_MINUS = 4'd1,
		PH_ZERO  = 4'd2,
		PH_INT   = 4'd3,
		PH_FRAC0 = 4'd4,
		PH_FRAC  = 4'd5,
		PH_EXP0  = 4'd6,
		PH_EXP   = 4'd7
	} phase_t;

	typedef enum logic {
		F_RUN,
		F_SCALE
	} fsm_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} scale_op_t;

	typedef struct packed {
		logic prod_big;   // mag * 10 above the positive limit
		logic sum_big;    // mag * 10 + digit above the positive limit
		logic near_min;   // mag * 10 is 2147483640 and the digit is 8
	} scale_flags_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_e(input logic [7:0] c);
		return (c == CH_UP_E) || (c == CH_LO_E);
	endfunction

endpackage

/* hdl/jnp_scale_unit.sv */
// ----------------------------------------------------------------------------
// jnp_scale_unit
// Shared 32x32 multiplier: times ten plus a digit, or divide by ten.
// ----------------------------------------------------------------------------
module jnp_scale_unit (
	input  jnp_pkg::scale_op_t    op,
	input  logic [31:0]           mag,
	input  logic [3:0]            digit,
	output logic [31:0]           scaled,
	output logic [31:0]           quot,
	output jnp_pkg::scale_flags_t flags
);
	import jnp_pkg::*;

	logic [31:0] mult_b;
	logic [63:0] product;
	logic [35:0] ten_x;
	logic [35:0] sum;

	assign mult_b  = (op == OP_DIV) ? RECIP10 : TEN;
	assign product = 64'(mag) * 64'(mult_b);
	assign ten_x   = product[35:0];
	assign sum     = ten_x + 36'(digit);

	assign scaled = sum[31:0];
	assign quot   = {3'b000, product[63:35]};

	assign flags.prod_big = ten_x > 36'(MAX_POS);
	assign flags.sum_big  = sum > 36'(MAX_POS);
	assign flags.near_min = (ten_x == 36'(NEAR_LIMIT)) && (digit == 4'd8);

endmodule

/* hdl/json_number_to_int32_parser.sv */
// ----------------------------------------------------------------------------
// json_number_to_int32_parser
// Takes the text of a JSON number one character per transfer and returns one
// signed 32-bit value with a status when the string ends (last set, or an
// empty_req transfer that carries no character). When an exponent is present,
// the end transfer is followed by one scaling step per exponent unit: the
// exponent is applied through a single shared multiplier (times ten, or divide
// by ten through a reciprocal product), so the end of a string like "1e255"
// holds char_stall until scaling is done, or until an overflow stops scaling
// early. Results sit in an output register; the next string's characters are
// accepted while a result waits unless that result is being stalled.
// ----------------------------------------------------------------------------
module json_number_to_int32_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  jnp_pkg::char_t   char_data,
	output logic             res_valid,
	input  logic             res_stall,
	output jnp_pkg::result_t res_data
);
	import jnp_pkg::*;

	// parser state
	phase_t      phase_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic        fracnz_q;
	logic [7:0]  ecnt_q;
	logic        eneg_q;
	logic        eseen_q;
	logic [2:0]  err_q;
	fsm_t        fsm_q;

	// output register
	logic        res_valid_q;
	result_t     res_q;

	// next values after taking one character
	phase_t      n_phase;
	logic [31:0] n_mag;
	logic        n_neg;
	logic        n_fracnz;
	logic [7:0]  n_ecnt;
	logic        n_eneg;
	logic        n_eseen;
	logic [2:0]  n_err;

	// end-of-string evaluation
	logic [2:0]  f_err;
	logic        go_scale;
	result_t     f_res;

	// one scaling step
	logic [31:0] s_mag;
	logic [2:0]  s_err;
	logic        s_done;
	result_t     s_res;

	// shared unit hookup
	scale_op_t    u_op;
	logic [3:0]   u_digit;
	logic [31:0]  u_scaled;
	logic [31:0]  u_quot;
	scale_flags_t u_flags;

	logic        acc;
	logic        is_end;
	logic        take;
	logic [3:0]  dig;
	logic [11:0] exp_t;

	function automatic result_t make_result(input logic [2:0] err, input logic fnz,
			input logic neg, input logic [31:0] mag);
		result_t r;
		if (err != STS_OK) begin
			r.value  = '0;
			r.status = err;
		end else begin
			r.value  = neg ? $signed(32'(32'd0 - mag)) : $signed(mag);
			r.status = fnz ? STS_FRAC : STS_OK;
		end
		return r;
	endfunction

	// a waiting result blocks new input only while it is itself stalled
	assign char_stall = (fsm_q != F_RUN) || (res_valid_q && res_stall);
	assign acc        = char_valid && !char_stall;
	assign is_end     = char_data.last || char_data.empty_req;
	assign take       = !char_data.empty_req && (err_q == STS_OK);
	assign dig        = 4'(char_data.ch - CH_ZERO);
	assign exp_t      = 12'(ecnt_q) * 12'd10 + 12'(dig);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// multiplier is shared between digit accumulation and exponent scaling
	assign u_op    = ((fsm_q == F_SCALE) && eneg_q) ? OP_DIV : OP_MUL;
	assign u_digit = (fsm_q == F_SCALE) ? 4'd0 : dig;

	jnp_scale_unit u_scale (
		.op     (u_op),
		.mag    (mag_q),
		.digit  (u_digit),
		.scaled (u_scaled),
		.quot   (u_quot),
		.flags  (u_flags)
	);

	// character decode
	always_comb begin
		n_phase  = phase_q;
		n_mag    = mag_q;
		n_neg    = neg_q;
		n_fracnz = fracnz_q;
		n_ecnt   = ecnt_q;
		n_eneg   = eneg_q;
		n_eseen  = eseen_q;
		n_err    = err_q;
		if (take) begin
			unique case (phase_q)
				PH_START, PH_MINUS: begin
					if (phase_q == PH_START && char_data.ch == CH_MINUS) begin
						n_neg   = 1'b1;
						n_phase = PH_MINUS;
					end else if (char_data.ch == CH_ZERO) begin
						n_phase = PH_ZERO;
					end else if (is_digit(char_data.ch)) begin
						n_phase = PH_INT;
						if (u_flags.prod_big) begin
							n_err = STS_OVERFLOW;
						end else if (u_flags.sum_big) begin
							if (u_flags.near_min && neg_q) n_mag = MIN_MAG;
							else n_err = STS_OVERFLOW;
						end else begin
							n_mag = u_scaled;
						end
					end else begin
						n_err = STS_SYNTAX;
					end
				end
				PH_ZERO, PH_INT: begin
					if (phase_q == PH_INT && is_digit(char_data.ch)) begin
						// accumulate one integer digit, most negative value allowed
						if (u_flags.prod_big) begin
							n_err = STS_OVERFLOW;
						end else if (u_flags.sum_big) begin
							if (u_flags.near_min && neg_q) n_mag = MIN_MAG;
							else n_err = STS_OVERFLOW;
						end else begin
							n_mag = u_scaled;
						end
					end else if (char_data.ch == CH_DOT) begin
						n_phase = PH_FRAC0;
					end else if (is_e(char_data.ch)) begin
						n_phase = PH_EXP0;
					end else begin
						n_err = STS_SYNTAX;
					end
				end
				PH_FRAC0, PH_FRAC: begin
					if (is_digit(char_data.ch)) begin
						if (dig != 4'd0) n_fracnz = 1'b1;
						n_phase = PH_FRAC;
					end else if (phase_q == PH_FRAC && is_e(char_data.ch)) begin
						n_phase = PH_EXP0;
					end else begin
						n_err = STS_SYNTAX;
					end
				end
				PH_EXP0: begin
					if (char_data.ch == CH_PLUS) begin
						n_phase = PH_EXP;
					end else if (char_data.ch == CH_MINUS) begin
						n_eneg  = 1'b1;
						n_phase = PH_EXP;
					end else if (is_digit(char_data.ch)) begin
						n_phase = PH_EXP;
						if (exp_t > 12'd255) begin
							n_err = STS_OVERFLOW;
						end else begin
							n_ecnt  = exp_t[7:0];
							n_eseen = 1'b1;
						end
					end else begin
						n_err = STS_SYNTAX;
					end
				end
				PH_EXP: begin
					if (is_digit(char_data.ch)) begin
						if (exp_t > 12'd255) begin
							n_err = STS_OVERFLOW;
						end else begin
							n_ecnt  = exp_t[7:0];
							n_eseen = 1'b1;
						end
					end else begin
						n_err = STS_SYNTAX;
					end
				end
				default: n_err = STS_SYNTAX;
			endcase
		end
	end

	// end of string: decide status, or hand off to exponent scaling
	always_comb begin
		f_err    = n_err;
		go_scale = 1'b0;
		if (n_err == STS_OK) begin
			unique case (n_phase)
				PH_START, PH_MINUS: f_err = STS_EOF;
				PH_ZERO, PH_INT, PH_FRAC: f_err = STS_OK;
				PH_EXP: begin
					// trailing e+ or e- with no digit
					if (!n_eseen) f_err = STS_SYNTAX;
					else if (n_ecnt != 8'd0) go_scale = 1'b1;
				end
				default: f_err = STS_SYNTAX;
			endcase
		end
		f_res = make_result(f_err, n_fracnz, n_neg, n_mag);
	end

	// one exponent step per cycle through the shared unit
	always_comb begin
		s_mag = mag_q;
		s_err = STS_OK;
		if (eneg_q) begin
			s_mag = u_quot;
		end else if (u_flags.prod_big) begin
			s_err = STS_OVERFLOW;
		end else begin
			s_mag = u_scaled;
		end
		s_done = (s_err != STS_OK) || (ecnt_q == 8'd1);
		s_res  = make_result(s_err, fracnz_q, neg_q, s_mag);
	end

	// sequencer and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= F_RUN;
			phase_q  <= PH_START;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			fracnz_q <= 1'b0;
			ecnt_q   <= '0;
			eneg_q   <= 1'b0;
			eseen_q  <= 1'b0;
			err_q    <= STS_OK;
		end else begin
			unique case (fsm_q)
				F_RUN: begin
					if (acc) begin
						if (is_end && !go_scale) begin
							// string done, back to reset values
							phase_q  <= PH_START;
							mag_q    <= '0;
							neg_q    <= 1'b0;
							fracnz_q <= 1'b0;
							ecnt_q   <= '0;
							eneg_q   <= 1'b0;
							eseen_q  <= 1'b0;
							err_q    <= STS_OK;
						end else begin
							phase_q  <= n_phase;
							mag_q    <= n_mag;
							neg_q    <= n_neg;
							fracnz_q <= n_fracnz;
							ecnt_q   <= n_ecnt;
							eneg_q   <= n_eneg;
							eseen_q  <= n_eseen;
							err_q    <= n_err;
							if (is_end) fsm_q <= F_SCALE;
						end
					end
				end
				F_SCALE: begin
					if (s_done) begin
						fsm_q    <= F_RUN;
						phase_q  <= PH_START;
						mag_q    <= '0;
						neg_q    <= 1'b0;
						fracnz_q <= 1'b0;
						ecnt_q   <= '0;
						eneg_q   <= 1'b0;
						eseen_q  <= 1'b0;
						err_q    <= STS_OK;
					end else begin
						mag_q  <= s_mag;
						ecnt_q <= ecnt_q - 8'd1;
					end
				end
				default: fsm_q <= F_RUN;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (fsm_q == F_RUN && acc && is_end && !go_scale) begin
				res_valid_q <= 1'b1;
			end else if (fsm_q == F_SCALE && s_done) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fsm_q == F_RUN && acc && is_end && !go_scale) begin
			res_q <= f_res;
		end else if (fsm_q == F_SCALE && s_done) begin
			res_q <= s_res;
		end
	end

endmodule

/* hdl/jnp_checker.sv */
// ----------------------------------------------------------------------------
// jnp_checker
// Port-level checks for the number parser, bound to the top level.
// ----------------------------------------------------------------------------
module jnp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             char_valid,
	input logic             char_stall,
	input jnp_pkg::char_t   char_data,
	input logic             res_valid,
	input logic             res_stall,
	input jnp_pkg::result_t res_data
);
	import jnp_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// an end transfer is followed by a result or by busy scaling
	a_end_resp: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && (char_data.last || char_data.empty_req)
		|=> res_valid || char_stall)
		else $error("end transfer without result or busy");

	// no input while a result is blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> char_stall)
		else $error("input taken while result blocked");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.status <= STS_EOF)
		else $error("status out of range");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == STS_SYNTAX || res_data.status == STS_OVERFLOW
		|| res_data.status == STS_EOF) |-> res_data.value == 32'sd0)
		else $error("nonzero value on error status");

endmodule

bind json_number_to_int32_parser jnp_checker u_jnp_checker (.*);
